@@ rtl/cma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cma_pkg;

  // symmetry operator components, Q.24 in 26 bits
  typedef logic signed [25:0] sym_op_t;

  localparam sym_op_t OP_0   = 26'sd0;
  localparam sym_op_t OP_1   = 26'sd16777216;
  localparam sym_op_t OP_H   = 26'sd8388608;
  localparam sym_op_t OP_NH  = -26'sd8388608;
  localparam sym_op_t OP_R2  = 26'sd11863283;
  localparam sym_op_t OP_NR2 = -26'sd11863283;
  localparam sym_op_t OP_R3  = 26'sd14529495;
  localparam sym_op_t OP_NR3 = -26'sd14529495;

  localparam int CUBIC_MAX = 24;
  localparam int HEX_NUM   = 12;
  localparam int NUM_TERMS = 12;

  // cosine arithmetic constants, Q.30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  localparam sym_op_t CUBIC_OP_TAB [CUBIC_MAX][4] = '{
    '{OP_1,  OP_0,   OP_0,   OP_0  }, '{OP_0,  OP_1,   OP_0,   OP_0  },
    '{OP_R2, OP_R2,  OP_0,   OP_0  }, '{OP_R2, OP_NR2, OP_0,   OP_0  },
    '{OP_0,  OP_0,   OP_1,   OP_0  }, '{OP_0,  OP_0,   OP_0,   OP_1  },
    '{OP_0,  OP_0,   OP_R2,  OP_NR2}, '{OP_0,  OP_0,   OP_R2,  OP_R2 },
    '{OP_R2, OP_0,   OP_0,   OP_NR2}, '{OP_H,  OP_H,   OP_H,   OP_NH },
    '{OP_0,  OP_R2,  OP_R2,  OP_0  }, '{OP_H,  OP_NH,  OP_NH,  OP_NH },
    '{OP_R2, OP_0,   OP_0,   OP_R2 }, '{OP_H,  OP_H,   OP_NH,  OP_H  },
    '{OP_0,  OP_R2,  OP_NR2, OP_0  }, '{OP_H,  OP_NH,  OP_H,   OP_H  },
    '{OP_R2, OP_0,   OP_R2,  OP_0  }, '{OP_H,  OP_H,   OP_H,   OP_H  },
    '{OP_0,  OP_R2,  OP_0,   OP_R2 }, '{OP_H,  OP_NH,  OP_H,   OP_NH },
    '{OP_R2, OP_0,   OP_NR2, OP_0  }, '{OP_H,  OP_H,   OP_NH,  OP_NH },
    '{OP_0,  OP_R2,  OP_0,   OP_NR2}, '{OP_H,  OP_NH,  OP_NH,  OP_H  }
  };

  localparam sym_op_t HEX_OP_TAB [HEX_NUM][4] = '{
    '{OP_1,  OP_0,  OP_0,   OP_0  }, '{OP_H,  OP_0,  OP_0,   OP_NR3},
    '{OP_H,  OP_0,  OP_0,   OP_R3 }, '{OP_R3, OP_0,  OP_0,   OP_NH },
    '{OP_0,  OP_0,  OP_0,   OP_1  }, '{OP_R3, OP_0,  OP_0,   OP_H  },
    '{OP_0,  OP_H,  OP_NR3, OP_0  }, '{OP_0,  OP_1,  OP_0,   OP_0  },
    '{OP_0,  OP_H,  OP_R3,  OP_0  }, '{OP_0,  OP_R3, OP_H,   OP_0  },
    '{OP_0,  OP_0,  OP_1,   OP_0  }, '{OP_0,  OP_R3, OP_NH,  OP_0  }
  };

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROT,
    B_DOT,
    B_ACOS,
    B_OUT
  } back_state_e;

  typedef enum logic [3:0] {
    A_IDLE,
    A_MID,
    A_X,
    A_X2,
    A_TMUL,
    A_RECIP,
    A_CHK,
    A_FIX,
    A_CMP
  } acos_state_e;

  // request to the arccosine unit: start strobe and clamped magnitude, Q.30
  typedef struct packed {
    logic        start;
    logic [30:0] mag;
  } acos_req_t;

  // operator component lookup
  function automatic sym_op_t sym_op(input logic hex, input logic [4:0] op,
                                     input logic [1:0] k);
    sym_op_t r;
    r = OP_0;
    if (hex) begin
      if (op < 5'd12) r = HEX_OP_TAB[op[3:0]][k];
    end else if (op < 5'd24) begin
      r = CUBIC_OP_TAB[op][k];
    end
    return r;
  endfunction

  // product term negated for output component c and operator component k
  function automatic logic rot_neg(input logic [1:0] c, input logic [1:0] k);
    logic r;
    unique case (c)
      2'd0:    r = (k != 2'd0);
      2'd1:    r = (k == 2'd3);
      2'd2:    r = (k == 2'd1);
      default: r = (k == 2'd2);
    endcase
    return r;
  endfunction

  // taylor divisor (2n-1)(2n)
  function automatic logic [9:0] term_div(input logic [3:0] n);
    logic [9:0] r;
    unique case (n)
      4'd1:    r = 10'd2;
      4'd2:    r = 10'd12;
      4'd3:    r = 10'd30;
      4'd4:    r = 10'd56;
      4'd5:    r = 10'd90;
      4'd6:    r = 10'd132;
      4'd7:    r = 10'd182;
      4'd8:    r = 10'd240;
      4'd9:    r = 10'd306;
      4'd10:   r = 10'd380;
      4'd11:   r = 10'd462;
      4'd12:   r = 10'd552;
      default: r = 10'd2;
    endcase
    return r;
  endfunction

  // reciprocal floor(2^32 / divisor), never above the true value
  function automatic logic [31:0] term_recip(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd357913941;
      4'd3:    r = 32'd143165576;
      4'd4:    r = 32'd76695844;
      4'd5:    r = 32'd47721858;
      4'd6:    r = 32'd32537631;
      4'd7:    r = 32'd23598721;
      4'd8:    r = 32'd17895697;
      4'd9:    r = 32'd14035840;
      4'd10:   r = 32'd11302545;
      4'd11:   r = 32'd9296466;
      4'd12:   r = 32'd7780737;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cma_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cma_front #(
  parameter int COMP_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [COMP_BITS-1:0] qa_i [4],
  input  wire logic signed [COMP_BITS-1:0] qb_i [4],
  output logic                             item_valid_o,
  input  wire logic                        item_ready_i,
  output logic                             item_hex_o,
  output logic signed [COMP_BITS-1:0]      qa_o [4],
  output logic signed [COMP_BITS-1:0]      qb_o [4]
);

  logic                        sym_q;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        wr_q, rd_q;
  logic signed [COMP_BITS-1:0] qa_st_q [2][4];
  logic signed [COMP_BITS-1:0] qb_st_q [2][4];
  logic                        hex_st_q [2];
  logic                        push, pop;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_valid_o && item_ready_i;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_hex_o   = hex_st_q[rd_q];
  assign qa_o         = qa_st_q[rd_q];
  assign qb_o         = qb_st_q[rd_q];

  // queue fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  // symmetry class register and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= 1'b0;
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) sym_q <= cfg_data_i;
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  // queue storage, each item tagged with its operator set
  always_ff @(posedge clk_i) begin
    if (push) begin
      qa_st_q[wr_q]  <= qa_i;
      qb_st_q[wr_q]  <= qb_i;
      hex_st_q[wr_q] <= sym_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cma_acos.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cma_acos #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cma_pkg::acos_req_t      req_i,
  output logic                    done_o,
  output logic [ANGLE_BITS-1:0]   angle_o
);

  cma_pkg::acos_state_e state_q, state_d;

  logic [ANGLE_BITS:0]   lo_q, hi_q, mid_q;
  logic [ANGLE_BITS+1:0] mid_sum;
  logic [30:0]           mag_q;
  logic [31:0]           x_q, x2_q, term_q, v_q, q0_q, chk_q;
  logic signed [33:0]    sum_q;
  logic [3:0]            n_q;
  logic                  done_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;
  logic [32:0]           rem;
  logic [31:0]           q_fix;
  logic [9:0]            cdiv;

  assign done_o  = done_q;
  assign angle_o = angle_q;
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign mid_sum = (ANGLE_BITS+2)'(lo_q) + (ANGLE_BITS+2)'(hi_q) + 1'b1;
  assign cdiv    = cma_pkg::term_div(n_q);
  assign rem     = {1'b0, v_q} - {1'b0, chk_q};
  assign q_fix   = (rem >= 33'(cdiv)) ? q0_q + 32'd1 : q0_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cma_pkg::A_IDLE:  if (req_i.start) state_d = cma_pkg::A_MID;
      cma_pkg::A_MID:   state_d = (lo_q < hi_q) ? cma_pkg::A_X : cma_pkg::A_IDLE;
      cma_pkg::A_X:     state_d = cma_pkg::A_X2;
      cma_pkg::A_X2:    state_d = cma_pkg::A_TMUL;
      cma_pkg::A_TMUL:  state_d = cma_pkg::A_RECIP;
      cma_pkg::A_RECIP: state_d = cma_pkg::A_CHK;
      cma_pkg::A_CHK:   state_d = cma_pkg::A_FIX;
      cma_pkg::A_FIX:   state_d = (n_q == 4'(cma_pkg::NUM_TERMS)) ? cma_pkg::A_CMP
                                                                  : cma_pkg::A_TMUL;
      cma_pkg::A_CMP:   state_d = cma_pkg::A_MID;
      default:          state_d = cma_pkg::A_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      cma_pkg::A_X: begin
        mul_a = 32'(mid_q);
        mul_b = cma_pkg::PI_Q30;
      end
      cma_pkg::A_X2: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      cma_pkg::A_TMUL: begin
        mul_a = term_q;
        mul_b = x2_q;
      end
      cma_pkg::A_RECIP: begin
        mul_a = v_q;
        mul_b = cma_pkg::term_recip(n_q);
      end
      cma_pkg::A_CHK: begin
        mul_a = q0_q;
        mul_b = 32'(cdiv);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cma_pkg::A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == cma_pkg::A_MID) && !(lo_q < hi_q);
    end
  end

  // binary search over angle codes, taylor cosine per probe
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cma_pkg::A_IDLE: begin
        if (req_i.start) begin
          lo_q  <= '0;
          hi_q  <= {1'b1, {ANGLE_BITS{1'b0}}};
          mag_q <= req_i.mag;
        end
      end
      cma_pkg::A_MID: begin
        mid_q <= mid_sum[ANGLE_BITS+1:1];
        if (!(lo_q < hi_q)) begin
          angle_q <= lo_q[ANGLE_BITS] ? {ANGLE_BITS{1'b1}} : lo_q[ANGLE_BITS-1:0];
        end
      end
      cma_pkg::A_X:     x_q <= 32'(prod >> (ANGLE_BITS + 1));
      cma_pkg::A_X2: begin
        x2_q   <= prod[61:30];
        term_q <= cma_pkg::ONE_Q30;
        sum_q  <= 34'(cma_pkg::ONE_Q30);
        n_q    <= 4'd1;
      end
      cma_pkg::A_TMUL:  v_q  <= prod[61:30];
      cma_pkg::A_RECIP: q0_q <= prod[63:32];
      cma_pkg::A_CHK:   chk_q <= prod[31:0];
      cma_pkg::A_FIX: begin
        term_q <= q_fix;
        if (n_q[0]) sum_q <= sum_q - $signed({2'b00, q_fix});
        else sum_q <= sum_q + $signed({2'b00, q_fix});
        n_q <= n_q + 4'd1;
      end
      cma_pkg::A_CMP: begin
        if (sum_q >= $signed({3'b000, mag_q})) lo_q <= mid_q;
        else hi_q <= mid_q - 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/cma_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cma_back #(
  parameter int NUM_SYM_OPS = 24,
  parameter int COMP_BITS   = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_valid_i,
  output logic                             item_ready_o,
  input  wire logic                        item_hex_i,
  input  wire logic signed [COMP_BITS-1:0] qa_i [4],
  input  wire logic signed [COMP_BITS-1:0] qb_i [4],
  output cma_pkg::acos_req_t               acos_req_o,
  input  wire logic                        acos_done_i,
  input  wire logic [ANGLE_BITS-1:0]       acos_angle_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ANGLE_BITS-1:0]            angle_o
);

  localparam int WF       = (COMP_BITS - 1 < 29) ? COMP_BITS - 1 : 29;
  localparam int SH       = 24 + COMP_BITS - 1 - WF;
  localparam int RW       = WF + 4;
  localparam int PW       = 26 + COMP_BITS;
  localparam int TW       = PW + 2;
  localparam int DW       = 2 * RW + 2;
  localparam int E        = 2 * WF;
  localparam int CUBIC_N  = (NUM_SYM_OPS > 24) ? 24 : ((NUM_SYM_OPS < 1) ? 1 : NUM_SYM_OPS);
  localparam int NOPS_MAX = (CUBIC_N > 12) ? CUBIC_N : 12;
  localparam int IW       = $clog2(NOPS_MAX);
  localparam logic [IW-1:0] CUBIC_LAST = IW'(CUBIC_N - 1);
  localparam logic [IW-1:0] HEX_LAST   = IW'(cma_pkg::HEX_NUM - 1);
  localparam logic [TW:0]   RND        = {{TW{1'b0}}, 1'b1} << (SH - 1);

  cma_pkg::back_state_e state_q, state_d;

  logic                 hex_q;
  logic [IW-1:0]        op_last;
  logic [IW+2:0]        rot_cnt_q;
  logic [IW-1:0]        rot_op;
  logic [1:0]           rot_comp;
  logic                 rot_quat;
  logic                 rot_last;
  logic                 rot_v_q;
  logic [IW-1:0]        rot_op_q;
  logic [1:0]           rot_comp_q;
  logic                 rot_quat_q;
  logic                 rot_neg_q [4];
  logic signed [PW-1:0] rot_p_q [4];
  logic signed [TW-1:0] rsum;
  logic [TW-1:0]        rabs;
  logic [TW:0]          rrnd;
  logic [RW-1:0]        rmag;
  logic signed [RW-1:0] rval;
  logic signed [RW-1:0] ra_q [NOPS_MAX][4];
  logic signed [RW-1:0] rb_q [NOPS_MAX][4];

  logic [IW-1:0]          i_q, j_q;
  logic                   dot_issued_q;
  logic                   dp_v_q, dm_v_q;
  logic signed [2*RW-1:0] dp_q [4];
  logic signed [DW-1:0]   dsum;
  logic [DW-1:0]          dm_q, best_q;
  logic [DW+29:0]         mwide;
  logic [30:0]            mag;
  logic                   dot_done;
  logic                   slot_free;
  logic                   out_valid_q;
  logic [ANGLE_BITS-1:0]  angle_q;

  assign op_last   = hex_q ? HEX_LAST : CUBIC_LAST;
  assign rot_op    = rot_cnt_q[IW+2:3];
  assign rot_quat  = rot_cnt_q[2];
  assign rot_comp  = rot_cnt_q[1:0];
  assign rot_last  = (rot_op == op_last) && (rot_cnt_q[2:0] == 3'b111);
  assign dot_done  = dot_issued_q && !dp_v_q && !dm_v_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  // rounded rotated component from the registered products
  always_comb begin
    rsum = '0;
    for (int k = 0; k < 4; k++) begin
      if (rot_neg_q[k]) rsum = rsum - TW'(rot_p_q[k]);
      else rsum = rsum + TW'(rot_p_q[k]);
    end
    rabs = (rsum < 0) ? TW'(-rsum) : TW'(rsum);
    rrnd = ({1'b0, rabs} + RND) >> SH;
    rmag = RW'(rrnd);
    rval = (rsum < 0) ? -$signed(rmag) : $signed(rmag);
  end

  // dot product sum and clamped magnitude of the best pair
  always_comb begin
    dsum = '0;
    for (int k = 0; k < 4; k++) dsum = dsum + DW'(dp_q[k]);
    mwide = {best_q, 30'b0} >> E;
    if (mwide > (DW+30)'(cma_pkg::ONE_Q30)) mag = cma_pkg::ONE_Q30[30:0];
    else mag = mwide[30:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cma_pkg::B_IDLE: if (item_valid_i) state_d = cma_pkg::B_ROT;
      cma_pkg::B_ROT:  if (rot_last) state_d = cma_pkg::B_DOT;
      cma_pkg::B_DOT:  if (dot_done) state_d = cma_pkg::B_ACOS;
      cma_pkg::B_ACOS: if (acos_done_i) state_d = cma_pkg::B_OUT;
      cma_pkg::B_OUT:  if (slot_free) state_d = cma_pkg::B_IDLE;
      default:         state_d = cma_pkg::B_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    item_ready_o     = (state_q == cma_pkg::B_ROT) && rot_last;
    acos_req_o.start = (state_q == cma_pkg::B_DOT) && dot_done;
    acos_req_o.mag   = mag;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cma_pkg::B_IDLE;
      rot_cnt_q    <= '0;
      rot_v_q      <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      dot_issued_q <= 1'b0;
      dp_v_q       <= 1'b0;
      dm_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hex_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      rot_v_q <= (state_q == cma_pkg::B_ROT);
      dp_v_q  <= (state_q == cma_pkg::B_DOT) && !dot_issued_q;
      dm_v_q  <= dp_v_q;
      if (state_q == cma_pkg::B_IDLE) begin
        hex_q        <= item_hex_i;
        rot_cnt_q    <= '0;
        i_q          <= '0;
        j_q          <= '0;
        dot_issued_q <= 1'b0;
      end
      if (state_q == cma_pkg::B_ROT) rot_cnt_q <= rot_cnt_q + 1'b1;
      // pair walk, second operator inner
      if ((state_q == cma_pkg::B_DOT) && !dot_issued_q) begin
        if (j_q == op_last) begin
          j_q <= '0;
          if (i_q == op_last) dot_issued_q <= 1'b1;
          else i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      // output register
      if ((state_q == cma_pkg::B_OUT) && slot_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath: operator products, rotated components, pair dot products
  always_ff @(posedge clk_i) begin
    if (state_q == cma_pkg::B_ROT) begin
      rot_op_q   <= rot_op;
      rot_comp_q <= rot_comp;
      rot_quat_q <= rot_quat;
      for (int k = 0; k < 4; k++) begin
        rot_neg_q[k] <= cma_pkg::rot_neg(rot_comp, 2'(k));
        rot_p_q[k]   <= cma_pkg::sym_op(hex_q, 5'(rot_op), 2'(k)) *
                        (rot_quat ? qb_i[rot_comp ^ 2'(k)] : qa_i[rot_comp ^ 2'(k)]);
      end
    end
    if (rot_v_q) begin
      if (rot_quat_q) rb_q[rot_op_q][rot_comp_q] <= rval;
      else ra_q[rot_op_q][rot_comp_q] <= rval;
    end
    for (int k = 0; k < 4; k++) dp_q[k] <= ra_q[i_q][k] * rb_q[j_q][k];
    dm_q <= (dsum < 0) ? DW'(-dsum) : DW'(dsum);
    if (state_q == cma_pkg::B_IDLE) best_q <= '0;
    else if (dm_v_q && (dm_q > best_q)) best_q <= dm_q;
    if ((state_q == cma_pkg::B_OUT) && slot_free) angle_q <= acos_angle_i;
  end

  // the arccosine unit only finishes while it is awaited
  a_acos_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acos_done_i |-> (state_q == cma_pkg::B_ACOS))
    else $error("arccosine result outside its wait state");

  // an item leaves the queue only if one is there
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_ready_o |-> item_valid_i)
    else $error("queue popped while empty");

  // pair walk stays inside the operator set
  a_pair_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cma_pkg::B_DOT && !dot_issued_q) |-> (i_q <= op_last && j_q <= op_last))
    else $error("operator pair index out of range");

  // a result is loaded only into a free output register
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(angle_q)))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

@@ rtl/crystal_misorientation_angle.sv @@
// per item: operator rotation, pair dot products and an arccosine binary search run
// one after another, with an item queue in front and an output register behind; the
// cubic set has NUM_SYM_OPS operators (at most 24), the hexagonal set 12
// throughput: one item is worked on at a time while the front queue holds up to two, set by
// the single shared multiplier of the arccosine unit and the pair walk
// reset: asynchronous, clears all control state and selects the cubic operators
`timescale 1ns / 1ps
`default_nettype none
module crystal_misorientation_angle #(
  parameter int NUM_SYM_OPS = 24,
  parameter int COMP_BITS   = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [COMP_BITS-1:0] a_w_i,
  input  wire logic signed [COMP_BITS-1:0] a_x_i,
  input  wire logic signed [COMP_BITS-1:0] a_y_i,
  input  wire logic signed [COMP_BITS-1:0] a_z_i,
  input  wire logic signed [COMP_BITS-1:0] b_w_i,
  input  wire logic signed [COMP_BITS-1:0] b_x_i,
  input  wire logic signed [COMP_BITS-1:0] b_y_i,
  input  wire logic signed [COMP_BITS-1:0] b_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ANGLE_BITS-1:0]            angle_o
);

  logic signed [COMP_BITS-1:0] qa_in [4];
  logic signed [COMP_BITS-1:0] qb_in [4];
  logic signed [COMP_BITS-1:0] qa_hd [4];
  logic signed [COMP_BITS-1:0] qb_hd [4];
  logic                        item_valid, item_ready, item_hex;
  cma_pkg::acos_req_t          acos_req;
  logic                        acos_done;
  logic [ANGLE_BITS-1:0]       acos_angle;

  assign qa_in = '{a_w_i, a_x_i, a_y_i, a_z_i};
  assign qb_in = '{b_w_i, b_x_i, b_y_i, b_z_i};

  // accept side with symmetry register and item queue
  cma_front #(
    .COMP_BITS(COMP_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .qa_i         (qa_in),
    .qb_i         (qb_in),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_hex_o   (item_hex),
    .qa_o         (qa_hd),
    .qb_o         (qb_hd)
  );

  // rotation, pair search and result register
  cma_back #(
    .NUM_SYM_OPS(NUM_SYM_OPS),
    .COMP_BITS  (COMP_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_hex_i   (item_hex),
    .qa_i         (qa_hd),
    .qb_i         (qb_hd),
    .acos_req_o   (acos_req),
    .acos_done_i  (acos_done),
    .acos_angle_i (acos_angle),
    .out_valid_o,
    .out_stall_i,
    .angle_o
  );

  // arccosine search
  cma_acos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_acos (
    .clk_i,
    .rst_ni,
    .req_i   (acos_req),
    .done_o  (acos_done),
    .angle_o (acos_angle)
  );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  typedef logic signed [15:0] comp_t;
  typedef comp_t pair_t [8];

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 6000;

  // expected angles and the fixed-point angle predictor
  class angle_scoreboard;
    logic [15:0] angle_q [$];
    int          errors;

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    // operator on the left, rounded half away from zero to Q.15
    function automatic void rotate(bit hex, int op, longint q [4], output longint r [4]);
      longint s [4];
      longint t [4];
      longint unsigned m;
      for (int k = 0; k < 4; k++) s[k] = longint'(cma_pkg::sym_op(hex, op[4:0], k[1:0]));
      t[0] = s[0]*q[0] - s[1]*q[1] - s[2]*q[2] - s[3]*q[3];
      t[1] = s[0]*q[1] + s[1]*q[0] + s[2]*q[3] - s[3]*q[2];
      t[2] = s[0]*q[2] - s[1]*q[3] + s[2]*q[0] + s[3]*q[1];
      t[3] = s[0]*q[3] + s[1]*q[2] - s[2]*q[1] + s[3]*q[0];
      for (int c = 0; c < 4; c++) begin
        m = (t[c] < 0) ? longint'(-t[c]) : t[c];
        m = (m + (64'd1 << 23)) >> 24;
        r[c] = (t[c] < 0) ? -longint'(m) : longint'(m);
      end
    endfunction

    // taylor cosine of code k, Q.30, in 64-bit arithmetic with unsigned terms and a signed sum
    function automatic longint cos_of_code(longint unsigned k);
      longint unsigned x, x2, term;
      longint sum;
      x = (k * 64'd3373259426) >> 17;
      x2 = (x * x) >> 30;
      term = 64'd1073741824;
      sum = 64'sd1073741824;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / longint'((2*n - 1) * (2*n));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      return sum;
    endfunction

    function automatic logic [15:0] predict(bit hex, pair_t it);
      longint qa [4], qb [4];
      longint ra [24][4], rb [24][4];
      longint d;
      longint unsigned best, mag, lo, hi, mid;
      int nops;
      nops = hex ? cma_pkg::HEX_NUM : cma_pkg::CUBIC_MAX;
      for (int c = 0; c < 4; c++) begin
        qa[c] = longint'(it[c]);
        qb[c] = longint'(it[4 + c]);
      end
      for (int i = 0; i < nops; i++) begin
        rotate(hex, i, qa, ra[i]);
        rotate(hex, i, qb, rb[i]);
      end
      best = 0;
      for (int i = 0; i < nops; i++) begin
        for (int j = 0; j < nops; j++) begin
          d = ra[i][0]*rb[j][0] + ra[i][1]*rb[j][1] + ra[i][2]*rb[j][2] + ra[i][3]*rb[j][3];
          mag = (d < 0) ? longint'(-d) : d;
          if (mag > best) best = mag;
        end
      end
      mag = (best > 64'd1073741824) ? 64'd1073741824 : best;
      lo = 0;
      hi = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (cos_of_code(mid) >= longint'(mag)) lo = mid;
        else hi = mid - 1;
      end
      if (lo > 64'd65535) lo = 64'd65535;
      return lo[15:0];
    endfunction

    function void note(bit hex, pair_t it);
      angle_q.push_back(predict(hex, it));
    endfunction

    task check(logic [15:0] got);
      logic [15:0] want;
      if (angle_q.size() == 0) begin
        report($sformatf("angle %0d with none expected", got));
      end else begin
        want = angle_q.pop_front();
        if (got !== want) report($sformatf("angle %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  comp_t a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  comp_t b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] angle_o;

  angle_scoreboard sb = new();
  bit   sym_hex = 1'b0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;

  crystal_misorientation_angle u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_w_i       (a_w_i),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_z_i       (a_z_i),
    .b_w_i       (b_w_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_z_i       (b_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_o     (angle_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = calm ? 1'b0 : ($urandom_range(0, 99) < 34);
    end
  end

  // result check and timeout
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(angle_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("crystal_misorientation_angle test failed");
      $finish;
    end
  end

  // one input transfer, with random gaps before it
  task send_pair(pair_t it);
    while (!calm && $urandom_range(0, 99) < 34) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    {a_w_i, a_x_i, a_y_i, a_z_i} = {it[0], it[1], it[2], it[3]};
    {b_w_i, b_x_i, b_y_i, b_z_i} = {it[4], it[5], it[6], it[7]};
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note(sym_hex, it);
  endtask

  task set_symmetry(bit hex);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.angle_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = hex;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sym_hex = hex;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // random unit quaternion in Q1.15
  task unit_quat(output comp_t q [4]);
    real c [4];
    real n;
    n = 0.0;
    while (n < 0.01) begin
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
        n += c[i] * c[i];
      end
      n = $sqrt(n) / 32768.0;
    end
    for (int i = 0; i < 4; i++) q[i] = comp_t'($rtoi(c[i] / n * 0.99997));
  endtask

  task random_pair(output pair_t it);
    comp_t qa [4], qb [4];
    int sel;
    sel = $urandom_range(0, 99);
    unit_quat(qa);
    unit_quat(qb);
    for (int i = 0; i < 4; i++) begin
      if (sel < 25) qb[i] = qa[i] + comp_t'(int'($urandom_range(0, 800)) - 400);
      else if (sel < 45) begin
        qa[i] = comp_t'($urandom);
        qb[i] = comp_t'($urandom);
      end
      it[i] = qa[i];
      it[4 + i] = qb[i];
    end
  endtask

  task random_phase(int count);
    pair_t it;
    for (int n = 0; n < count; n++) begin
      random_pair(it);
      send_pair(it);
    end
  endtask

  localparam comp_t ONE = 16'sd32767;
  localparam comp_t NEG = -16'sd32768;
  localparam comp_t HALF = 16'sd16384;
  localparam comp_t R2 = 16'sd23170;

  initial begin
    pair_t directed [$];
    // identical, zero, extremes, unnormalised, symmetry-equivalent and half-turn pairs
    directed.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0});
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{NEG, NEG, NEG, NEG, NEG, NEG, NEG, NEG});
    directed.push_back('{ONE, ONE, ONE, ONE, NEG, NEG, NEG, NEG});
    directed.push_back('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    directed.push_back('{ONE, 0, 0, 0, 0, ONE, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, R2, R2, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, HALF, HALF, HALF, HALF});
    directed.push_back('{R2, 0, 0, R2, ONE, 0, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, 16'sd30274, 16'sd12540, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, 16'sd32000, 16'sd7040, 0, 0});
    directed.push_back('{ONE, 0, 0, 0, 16'sd28378, 0, 0, 16'sd16384});
    directed.push_back('{NEG, 0, 0, 0, ONE, 0, 0, 0});
    directed.push_back('{1, -1, 1, -1, -1, 1, -1, 1});
    directed.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                         16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_pair(directed[i]);
    set_symmetry(1'b1);
    foreach (directed[i]) send_pair(directed[i]);

    // hexagonal, opening with a stretch of no gaps on either side
    calm = 1'b1;
    random_phase(60);
    calm = 1'b0;
    random_phase(60);

    // cubic, with a long result hold-off while items keep coming
    set_symmetry(1'b0);
    hold_req = 1'b1;
    random_phase(150);

    set_symmetry(1'b1);
    random_phase(60);
    set_symmetry(1'b0);
    random_phase(70);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.angle_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("crystal_misorientation_angle test passed");
    end else begin
      $display("crystal_misorientation_angle test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cma_pkg.sv
rtl/cma_front.sv
rtl/cma_acos.sv
rtl/cma_back.sv
rtl/crystal_misorientation_angle.sv
sim/testbench.sv
